// ===== hw/rtl/wtlru_pkg.sv =====
// Shared types and constants for the write-through LRU block cache tag engine.
package wtlru_pkg;

  // Width of the device size register.
  localparam int unsigned BLOCKS_W    = 49;
  // Width of a slot's recency stamp and of the access clock.
  localparam int unsigned STAMP_W     = 64;
  // Width of the slot field of a result.
  localparam int unsigned SLOT_W      = 6;
  // Number of entries in the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_DEV_ERR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_LAST,
    BK_UPDATE
  } back_state_e;

  // Classification of one accepted access, made by the front.
  typedef struct packed {
    logic is_write;
    logic failed;
    logic invalid;
  } item_ctrl_t;

  localparam int unsigned CTRL_W = $bits(item_ctrl_t);

  // One result beat, produced by the back.
  typedef struct packed {
    status_e             status;
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                dev_read;
    logic                dev_write;
  } result_t;

endpackage

// ===== hw/rtl/write_through_lru_block_cache_tags_top.sv =====
// Top level of the write-through LRU block cache tag and replacement engine.
//
//   Channel   Handshake                      Payload
//   --------  -----------------------------  -------------------------------------------
//   access    start high, busy low           action_i, block_address_i, device_failed_i
//   result    result_strobe_o, one cycle     status_o, hit_o, slot_o, device_read_o,
//                                            device_write_o
//   config    dev_blocks_we_i, no wait       dev_blocks_i
//
// A valid access reaches its result beat after a scan of the tag and stamp memories
// through their single read port.
// An invalid address gives its result in the cycle after it leaves the queue.
// Up to two accepted beats wait in the queue; busy is high while it is full.
// Reset clears the stamp valid bits at once, so no clearing pass is needed.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module write_through_lru_block_cache_tags_top #(
  parameter int unsigned SLOTS        = 64,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           action_i,
  input  logic [ADDRESS_BITS-1:0]        block_address_i,
  input  logic                           device_failed_i,
  input  logic                           dev_blocks_we_i,
  input  logic [wtlru_pkg::BLOCKS_W-1:0] dev_blocks_i,
  output logic                           result_strobe_o,
  output logic [1:0]                     status_o,
  output logic                           hit_o,
  output logic [wtlru_pkg::SLOT_W-1:0]   slot_o,
  output logic                           device_read_o,
  output logic                           device_write_o
);
  import wtlru_pkg::*;

  localparam int unsigned Q_W = CTRL_W + ADDRESS_BITS;

  logic                    q_push;
  logic                    q_pop;
  logic                    q_empty;
  logic                    q_full;
  item_ctrl_t              push_ctrl;
  logic [ADDRESS_BITS-1:0] push_addr;
  logic [Q_W-1:0]          q_wdata;
  logic [Q_W-1:0]          q_rdata;
  item_ctrl_t              pop_ctrl;
  logic [ADDRESS_BITS-1:0] pop_addr;
  result_t                 result;

  wtlru_front #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .action_i       (action_i),
    .block_address_i(block_address_i),
    .device_failed_i(device_failed_i),
    .dev_blocks_we_i(dev_blocks_we_i),
    .dev_blocks_i   (dev_blocks_i),
    .full_i         (q_full),
    .push_o         (q_push),
    .ctrl_o         (push_ctrl),
    .addr_o         (push_addr)
  );

  assign q_wdata = {push_ctrl, push_addr};

  wtlru_queue #(
    .DATA_W(Q_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  assign pop_ctrl = item_ctrl_t'(q_rdata[Q_W-1:ADDRESS_BITS]);
  assign pop_addr = q_rdata[ADDRESS_BITS-1:0];

  wtlru_back #(
    .SLOTS       (SLOTS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .ctrl_i      (pop_ctrl),
    .addr_i      (pop_addr),
    .pop_o       (q_pop),
    .result_o    (result),
    .result_vld_o(result_strobe_o)
  );

  // Result beat onto the ports.
  assign status_o       = result.status;
  assign hit_o          = result.hit;
  assign slot_o         = result.slot;
  assign device_read_o  = result.dev_read;
  assign device_write_o = result.dev_write;

  // An invalid address touches nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && (status_o == ST_INVALID) |->
      !hit_o && !device_read_o && !device_write_o && (slot_o == '0))
    else $error("invalid access reported a slot or device transfer");

  // A device fill happens only on a read miss.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && device_read_o |-> !hit_o && !device_write_o)
    else $error("device fill on a hit or a write");

  // A read hit never involves the device and always succeeds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && hit_o && !device_write_o |-> (status_o == ST_OK))
    else $error("read hit reported an error");

  // The queue is never popped while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

// ===== hw/rtl/wtlru_queue.sv =====
// Short queue that decouples the accepting front from the scanning back.
module wtlru_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o,
  output logic              full_o
);
  import wtlru_pkg::*;

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FULL_CNT);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/wtlru_front.sv =====
// Front end: accepts access beats, holds the device size and flags invalid addresses.
module wtlru_front #(
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           action_i,
  input  logic [ADDRESS_BITS-1:0]        block_address_i,
  input  logic                           device_failed_i,
  input  logic                           dev_blocks_we_i,
  input  logic [wtlru_pkg::BLOCKS_W-1:0] dev_blocks_i,
  input  logic                           full_i,
  output logic                           push_o,
  output wtlru_pkg::item_ctrl_t          ctrl_o,
  output logic [ADDRESS_BITS-1:0]        addr_o
);
  import wtlru_pkg::*;

  localparam int unsigned CMP_W = (ADDRESS_BITS > BLOCKS_W) ? ADDRESS_BITS : BLOCKS_W;

  logic [BLOCKS_W-1:0] dev_blocks_q;
  logic [CMP_W-1:0]    addr_ext;
  logic [CMP_W-1:0]    blocks_ext;

  // Device size register, one block after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_blocks_q <= BLOCKS_W'(1);
    end else if (dev_blocks_we_i) begin
      dev_blocks_q <= dev_blocks_i;
    end
  end

  // A beat is taken whenever the queue has room.
  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  // Address range check against the device size.
  assign addr_ext   = CMP_W'(block_address_i);
  assign blocks_ext = CMP_W'(dev_blocks_q);

  always_comb begin
    ctrl_o.is_write = action_i;
    ctrl_o.failed   = device_failed_i;
    ctrl_o.invalid  = (addr_ext >= blocks_ext);
  end

  assign addr_o = block_address_i;

endmodule

// ===== hw/rtl/wtlru_back.sv =====
// Back end: scans the tag and stamp memories, picks hit or victim, updates and reports.
module wtlru_back #(
  parameter int unsigned SLOTS        = 64,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty_i,
  input  wtlru_pkg::item_ctrl_t   ctrl_i,
  input  logic [ADDRESS_BITS-1:0] addr_i,
  output logic                    pop_o,
  output wtlru_pkg::result_t      result_o,
  output logic                    result_vld_o
);
  import wtlru_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  back_state_e state_q, state_d;

  // Current access.
  item_ctrl_t              cur_ctrl_q;
  logic [ADDRESS_BITS-1:0] cur_addr_q;

  // Memories and their registered read data.
  logic [ADDRESS_BITS-1:0] tag_mem   [SLOTS];
  logic [STAMP_W-1:0]      stamp_mem [SLOTS];
  logic [SLOTS-1:0]        stamp_vld_q;
  logic [ADDRESS_BITS-1:0] tag_rd_q;
  logic [STAMP_W-1:0]      stamp_rd_q;
  logic                    svld_rd_q;
  logic [STAMP_W-1:0]      cmp_stamp;

  // Scan control and running results.
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic               cmp_en_q;
  logic [IDX_W-1:0]   cmp_idx_q;
  logic               found_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic [IDX_W-1:0]   vic_idx_q;
  logic [STAMP_W-1:0] vic_stamp_q;
  logic               match;

  // Access clock.
  logic [STAMP_W-1:0] clock_q, clock_d;
  logic [STAMP_W-1:0] clock_inc;

  // Update controls.
  logic                     tag_we;
  logic                     stamp_we;
  logic [STAMP_W-1:0]       stamp_wval;
  logic [IDX_W-1:0]         tgt_idx;
  logic [IDX_W+SLOT_W-1:0]  tgt_ext;

  result_t res_q, res_d;
  logic    res_vld_q, res_vld_d;

  assign clock_inc = clock_q + STAMP_W'(1);
  assign tgt_idx   = found_q ? hit_idx_q : vic_idx_q;
  assign tgt_ext   = {{SLOT_W{1'b0}}, tgt_idx};
  assign cmp_stamp = svld_rd_q ? stamp_rd_q : '0;
  assign match     = (cmp_stamp != '0) && (tag_rd_q == cur_addr_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i && !ctrl_i.invalid) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (rd_idx_q == LAST_IDX) begin
          state_d = BK_LAST;
        end
      end
      BK_LAST:   state_d = BK_UPDATE;
      BK_UPDATE: state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // Outputs of each state: pop, scan address, memory writes and result.
  always_comb begin
    pop_o      = 1'b0;
    rd_idx_d   = rd_idx_q;
    tag_we     = 1'b0;
    stamp_we   = 1'b0;
    stamp_wval = clock_inc;
    clock_d    = clock_q;
    res_vld_d  = 1'b0;
    res_d      = res_q;
    case (state_q)
      BK_IDLE: begin
        rd_idx_d = '0;
        if (!empty_i) begin
          pop_o = 1'b1;
          if (ctrl_i.invalid) begin
            res_vld_d       = 1'b1;
            res_d.status    = ST_INVALID;
            res_d.hit       = 1'b0;
            res_d.slot      = '0;
            res_d.dev_read  = 1'b0;
            res_d.dev_write = 1'b0;
          end
        end
      end
      BK_SCAN: begin
        if (rd_idx_q != LAST_IDX) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      BK_LAST: begin
        rd_idx_d = rd_idx_q;
      end
      BK_UPDATE: begin
        res_vld_d       = 1'b1;
        res_d.status    = ST_OK;
        res_d.hit       = found_q;
        res_d.slot      = tgt_ext[SLOT_W-1:0];
        res_d.dev_read  = 1'b0;
        res_d.dev_write = 1'b0;
        if (!cur_ctrl_q.is_write) begin
          if (found_q) begin
            // Read hit: refresh the stamp, device outcome does not matter.
            stamp_we = 1'b1;
            clock_d  = clock_inc;
          end else begin
            res_d.dev_read = 1'b1;
            stamp_we       = 1'b1;
            if (cur_ctrl_q.failed) begin
              // Failed fill empties the victim and leaves the clock alone.
              stamp_wval   = '0;
              res_d.status = ST_DEV_ERR;
            end else begin
              tag_we  = 1'b1;
              clock_d = clock_inc;
            end
          end
        end else begin
          // Every valid write goes through to the device.
          res_d.dev_write = 1'b1;
          tag_we          = !found_q;
          stamp_we        = 1'b1;
          clock_d         = clock_inc;
          if (cur_ctrl_q.failed) begin
            stamp_wval   = '0;
            res_d.status = ST_DEV_ERR;
          end
        end
      end
      default: begin
        rd_idx_d = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rd_idx_q    <= '0;
      cmp_en_q    <= 1'b0;
      found_q     <= 1'b0;
      clock_q     <= '0;
      stamp_vld_q <= '0;
      res_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      cmp_en_q  <= (state_q == BK_SCAN);
      clock_q   <= clock_d;
      res_vld_q <= res_vld_d;
      if (pop_o) begin
        found_q <= 1'b0;
      end else if (cmp_en_q && match) begin
        found_q <= 1'b1;
      end
      if (stamp_we) begin
        stamp_vld_q[tgt_idx] <= 1'b1;
      end
    end
  end

  // Payload registers: current access, scan results and result beat.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_ctrl_q <= ctrl_i;
      cur_addr_q <= addr_i;
    end
    cmp_idx_q <= rd_idx_q;
    if (cmp_en_q && match && !found_q) begin
      hit_idx_q <= cmp_idx_q;
    end
    // Strictly smaller keeps the lowest index among equal stamps.
    if (cmp_en_q && ((cmp_idx_q == '0) || (cmp_stamp < vic_stamp_q))) begin
      vic_idx_q   <= cmp_idx_q;
      vic_stamp_q <= cmp_stamp;
    end
    res_q <= res_d;
  end

  // Tag and stamp memories: one registered read and one write per cycle.
  always_ff @(posedge clk_i) begin
    tag_rd_q   <= tag_mem[rd_idx_q];
    stamp_rd_q <= stamp_mem[rd_idx_q];
    svld_rd_q  <= stamp_vld_q[rd_idx_q];
    if (tag_we) begin
      tag_mem[tgt_idx] <= cur_addr_q;
    end
    if (stamp_we) begin
      stamp_mem[tgt_idx] <= stamp_wval;
    end
  end

  assign result_o     = res_q;
  assign result_vld_o = res_vld_q;

endmodule
